### hw/rtl/twb_pkg.sv
package twb_pkg;

  localparam int unsigned TS_W      = 48;
  localparam int unsigned TNS_W     = 52;
  localparam int unsigned WINDOW_W  = 31;
  localparam int unsigned ENERGY_W  = 16;
  localparam int unsigned CFD_W     = 16;
  localparam int unsigned EVT_W     = 32;
  localparam int unsigned BOARD_W   = 2;
  localparam int unsigned CHAN_W    = 4;
  localparam int unsigned SLOT_W    = 4;
  localparam int unsigned IDX_CALC_W = 7;

  localparam logic [WINDOW_W-1:0] WINDOW_RESET = 31'd1000;

  localparam int unsigned QUEUE_PTR_W = 2;
  localparam int unsigned QUEUE_DEPTH = 1 << QUEUE_PTR_W;

  typedef enum logic {
    OP_HIT   = 1'b0,
    OP_FLUSH = 1'b1
  } op_e;

  typedef struct packed {
    logic                op;
    logic [ENERGY_W-1:0] energy;
    logic [TS_W-1:0]     timestamp;
    logic [CHAN_W-1:0]   channel;
    logic [SLOT_W-1:0]   slot;
    logic [CFD_W-1:0]    cfd_fraction;
    logic                cfd_forced;
  } hit_t;

  typedef struct packed {
    logic [EVT_W-1:0]    event_number;
    logic [BOARD_W-1:0]  board;
    logic [CHAN_W-1:0]   out_channel;
    logic [ENERGY_W-1:0] max_energy;
    logic [TS_W-1:0]     hit_time;
    logic [CFD_W-1:0]    hit_cfd;
    logic                hit_cfd_forced;
    logic                last;
  } result_t;

  // one stored hit per board/channel
  typedef struct packed {
    logic [ENERGY_W-1:0] energy;
    logic [TS_W-1:0]     timestamp;
    logic [CFD_W-1:0]    cfd;
    logic                forced;
  } entry_t;

  // front -> back command; emit runs first, then store
  typedef struct packed {
    logic                emit;
    logic                store;
    logic [BOARD_W-1:0]  board;
    logic [CHAN_W-1:0]   channel;
    entry_t              hit;
  } cmd_t;

  // readout slot in flight behind the RAM read register
  typedef struct packed {
    logic [EVT_W-1:0]   event_number;
    logic [BOARD_W-1:0] board;
    logic [CHAN_W-1:0]  channel;
    logic               last;
    logic               entry_valid;
  } pend_t;

endpackage

### hw/rtl/twb_ram.sv
module twb_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hw/rtl/twb_front.sv
module twb_front #(
  parameter int unsigned BOARDS      = 4,
  parameter int unsigned CHANNELS    = 16,
  parameter int unsigned SLOT_OFFSET = 2
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  twb_pkg::hit_t                  in_data_i,
  input  logic [twb_pkg::WINDOW_W-1:0]   window_i,
  input  logic                           full_i,
  output logic                           push_o,
  output twb_pkg::cmd_t                  cmd_o
);

  import twb_pkg::*;

  logic             f_vld_q, f_vld_d;
  hit_t             f_hit_q;
  logic [TNS_W-1:0] f_t10_q;
  logic             open_q, open_d;
  logic [TNS_W-1:0] start_q, start_d;

  logic             accept;
  logic             go;
  logic [TNS_W:0]   diff;
  logic             in_win;
  logic [SLOT_W-1:0] board_raw;
  logic             in_rng;

  assign go         = f_vld_q && !full_i;
  assign in_stall_o = f_vld_q && full_i;
  assign accept     = in_valid_i && !in_stall_o;

  // borrow out of the wide subtract means the hit precedes the start
  assign diff   = {1'b0, f_t10_q} - {1'b0, start_q};
  assign in_win = !diff[TNS_W] && (diff[TNS_W-1:0] <= {{(TNS_W-WINDOW_W){1'b0}}, window_i});

  assign board_raw = f_hit_q.slot - SLOT_W'(SLOT_OFFSET);
  assign in_rng = (f_hit_q.slot >= SLOT_W'(SLOT_OFFSET))
               && ({1'b0, board_raw} < (SLOT_W+1)'(BOARDS))
               && ({1'b0, f_hit_q.channel} < (CHAN_W+1)'(CHANNELS));

  always_comb begin
    push_o            = 1'b0;
    open_d            = open_q;
    start_d           = start_q;
    cmd_o.emit        = 1'b0;
    cmd_o.store       = 1'b0;
    cmd_o.board       = board_raw[BOARD_W-1:0];
    cmd_o.channel     = f_hit_q.channel;
    cmd_o.hit.energy    = f_hit_q.energy;
    cmd_o.hit.timestamp = f_hit_q.timestamp;
    cmd_o.hit.cfd       = f_hit_q.cfd_fraction;
    cmd_o.hit.forced    = f_hit_q.cfd_forced;
    if (go) begin
      if (f_hit_q.op == OP_FLUSH) begin
        if (open_q) begin
          push_o     = 1'b1;
          cmd_o.emit = 1'b1;
        end
        open_d = 1'b0;
      end else if (!open_q) begin
        open_d      = 1'b1;
        start_d     = f_t10_q;
        push_o      = in_rng;
        cmd_o.store = in_rng;
      end else if (in_win) begin
        push_o      = in_rng;
        cmd_o.store = in_rng;
      end else begin
        start_d     = f_t10_q;
        push_o      = 1'b1;
        cmd_o.emit  = 1'b1;
        cmd_o.store = in_rng;
      end
    end
  end

  assign f_vld_d = accept || (f_vld_q && !go);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_vld_q <= 1'b0;
      open_q  <= 1'b0;
      start_q <= '0;
    end else begin
      f_vld_q <= f_vld_d;
      open_q  <= open_d;
      start_q <= start_d;
    end
  end

  // hit time in ns: ticks * 8 + ticks * 2
  always_ff @(posedge clk_i) begin
    if (accept) begin
      f_hit_q <= in_data_i;
      f_t10_q <= TNS_W'({in_data_i.timestamp, 3'b000}) + TNS_W'({in_data_i.timestamp, 1'b0});
    end
  end

endmodule

### hw/rtl/twb_cmd_fifo.sv
module twb_cmd_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  twb_pkg::cmd_t cmd_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          empty_o,
  output twb_pkg::cmd_t cmd_o
);

  import twb_pkg::*;

  cmd_t                   mem_q [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QUEUE_PTR_W:0]   count_q;

  assign full_o  = (count_q == (QUEUE_PTR_W+1)'(QUEUE_DEPTH));
  assign empty_o = (count_q == '0);
  assign cmd_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

### hw/rtl/twb_back.sv
module twb_back #(
  parameter int unsigned BOARDS   = 4,
  parameter int unsigned CHANNELS = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             empty_i,
  input  twb_pkg::cmd_t    cmd_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output twb_pkg::result_t out_data_o
);

  import twb_pkg::*;

  localparam int unsigned SLOTS = BOARDS * CHANNELS;
  localparam int unsigned IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  typedef enum logic [3:0] {
    B_IDLE  = 4'b0001,
    B_SWEEP = 4'b0010,
    B_RD    = 4'b0100,
    B_CMP   = 4'b1000
  } back_state_e;

  back_state_e        state_q, state_d;
  cmd_t               cmd_q, cmd_d;
  logic [IDX_W-1:0]   i_q, i_d;
  logic [BOARD_W-1:0] b_q, b_d;
  logic [CHAN_W-1:0]  c_q, c_d;
  logic [EVT_W-1:0]   count_q, count_d;
  logic [SLOTS-1:0]   valid_q, valid_d;
  logic               rv_q, rv_d;
  pend_t              pend_q, pend_d;
  logic               out_vld_q, out_vld_d;
  result_t            out_q, out_d;

  logic                  ram_we, ram_re;
  logic [IDX_W-1:0]      ram_raddr;
  logic [$bits(entry_t)-1:0] ram_rdata;
  entry_t                rd_entry;
  logic [IDX_CALC_W-1:0] idx_full;
  logic [IDX_W-1:0]      st_idx;
  logic [ENERGY_W-1:0]   cur_energy;
  logic                  out_load;
  logic                  stage_free;
  logic                  sw_issue;
  logic                  sw_last;

  assign rd_entry = entry_t'(ram_rdata);
  assign idx_full = IDX_CALC_W'(cmd_q.board) * IDX_CALC_W'(CHANNELS)
                  + IDX_CALC_W'(cmd_q.channel);
  assign st_idx   = idx_full[IDX_W-1:0];
  assign cur_energy = valid_q[st_idx] ? rd_entry.energy : '0;

  assign out_load   = rv_q && (!out_vld_q || !out_stall_i);
  assign stage_free = !rv_q || out_load;
  assign sw_issue   = (state_q == B_SWEEP) && stage_free;
  assign sw_last    = sw_issue && (i_q == IDX_W'(SLOTS - 1));

  twb_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (SLOTS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (st_idx),
    .wdata_i (cmd_q.hit),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    state_d   = state_q;
    cmd_d     = cmd_q;
    i_d       = i_q;
    b_d       = b_q;
    c_d       = c_q;
    count_d   = count_q;
    valid_d   = valid_q;
    pop_o     = 1'b0;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_raddr = i_q;
    pend_d    = pend_q;
    rv_d      = rv_q && !out_load;

    unique case (state_q)
      B_IDLE: begin
        if (!empty_i) begin
          pop_o   = 1'b1;
          cmd_d   = cmd_i;
          state_d = cmd_i.emit ? B_SWEEP : B_RD;
        end
      end
      B_SWEEP: begin
        if (sw_issue) begin
          ram_re              = 1'b1;
          rv_d                = 1'b1;
          pend_d.event_number = count_q;
          pend_d.board        = b_q;
          pend_d.channel      = c_q;
          pend_d.last         = sw_last;
          pend_d.entry_valid  = valid_q[i_q];
          if (sw_last) begin
            i_d     = '0;
            b_d     = '0;
            c_d     = '0;
            valid_d = '0;
            count_d = count_q + 1'b1;
            state_d = cmd_q.store ? B_RD : B_IDLE;
          end else begin
            i_d = i_q + 1'b1;
            if (c_q == CHAN_W'(CHANNELS - 1)) begin
              c_d = '0;
              b_d = b_q + 1'b1;
            end else begin
              c_d = c_q + 1'b1;
            end
          end
        end
      end
      B_RD: begin
        // the read register still holds readout data until it moves on
        if (!rv_q) begin
          ram_re    = 1'b1;
          ram_raddr = st_idx;
          state_d   = B_CMP;
        end
      end
      B_CMP: begin
        if (cmd_q.hit.energy > cur_energy) begin
          ram_we          = 1'b1;
          valid_d[st_idx] = 1'b1;
        end
        state_d = B_IDLE;
      end
      default: begin
        state_d = B_IDLE;
      end
    endcase
  end

  always_comb begin
    out_d     = out_q;
    out_vld_d = out_vld_q && out_stall_i;
    if (out_load) begin
      out_vld_d            = 1'b1;
      out_d.event_number   = pend_q.event_number;
      out_d.board          = pend_q.board;
      out_d.out_channel    = pend_q.channel;
      out_d.last           = pend_q.last;
      out_d.max_energy     = pend_q.entry_valid ? rd_entry.energy : '0;
      out_d.hit_time       = pend_q.entry_valid ? rd_entry.timestamp : '0;
      out_d.hit_cfd        = pend_q.entry_valid ? rd_entry.cfd : '0;
      out_d.hit_cfd_forced = pend_q.entry_valid && rd_entry.forced;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= B_IDLE;
      i_q       <= '0;
      b_q       <= '0;
      c_q       <= '0;
      count_q   <= '0;
      valid_q   <= '0;
      rv_q      <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      i_q       <= i_d;
      b_q       <= b_d;
      c_q       <= c_d;
      count_q   <= count_d;
      valid_q   <= valid_d;
      rv_q      <= rv_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q  <= cmd_d;
    pend_q <= pend_d;
    out_q  <= out_d;
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> !empty_i)
    else $error("command popped from empty queue");

  a_rdata_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rv_q && !out_load) |=> (rv_q && $stable(ram_rdata)))
    else $error("pending readout data overwritten");

  a_clear_after_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sw_last |=> (valid_q == '0))
    else $error("store not cleared after event readout");

  a_cmp_no_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == B_CMP) |-> !rv_q)
    else $error("store compare overlaps readout data");
`endif

endmodule

### hw/rtl/time_window_event_builder.sv
// Time window event builder.
// Input channel (in_valid_i / in_stall_o / in_data_i): one transaction per hit
// or flush. A hit within window_ns of the event start joins the event; each
// board/channel keeps its largest-energy hit. A hit outside the window closes
// the event and opens the next one; a flush closes the open event.
// Output channel (out_valid_o / out_stall_i / out_data_o): a closed event
// comes out as BOARDS*CHANNELS transactions, board by board, channel by
// channel, with last set on the final one.
// Config channel (cfg_valid_i / cfg_ready_o / cfg_data_i): writes window_ns;
// always ready, write only while the block is idle.
// Throughput: the front takes one transaction per cycle while the queue is not full
// into a four-entry command queue; the back handles each stored hit as pop, RAM
// read, compare/write through the store RAM write port, and reads out an event
// one slot per cycle while not stalled. out_valid_o rises once the closing
// transaction passes the front register, queue, sweep and RAM read register.
// Out-of-range boards/channels still open and close events but are not stored.
// Reset: no event open, event number 0, window 1000 ns, store reads empty
// through per-entry valid flags (no clearing pass). out_stall_i holds the
// output register; the back and then the queue fill and in_stall_o rises.
module time_window_event_builder #(
  parameter int unsigned BOARDS      = 4,
  parameter int unsigned CHANNELS    = 16,
  parameter int unsigned SLOT_OFFSET = 2
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  twb_pkg::hit_t                in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output twb_pkg::result_t             out_data_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [twb_pkg::WINDOW_W-1:0] cfg_data_i
);

  import twb_pkg::*;

  logic [WINDOW_W-1:0] window_q;
  logic                push;
  logic                pop;
  logic                full;
  logic                empty;
  cmd_t                cmd_in;
  cmd_t                cmd_out;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= WINDOW_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      window_q <= cfg_data_i;
    end
  end

  twb_front #(
    .BOARDS      (BOARDS),
    .CHANNELS    (CHANNELS),
    .SLOT_OFFSET (SLOT_OFFSET)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .window_i   (window_q),
    .full_i     (full),
    .push_o     (push),
    .cmd_o      (cmd_in)
  );

  twb_cmd_fifo u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (cmd_in),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .cmd_o   (cmd_out)
  );

  twb_back #(
    .BOARDS   (BOARDS),
    .CHANNELS (CHANNELS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .cmd_i       (cmd_out),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

### dv/tb.sv
`timescale 1ns / 100ps

module tb;
  import twb_pkg::*;

  localparam int unsigned BOARDS      = 4;
  localparam int unsigned CHANNELS    = 16;
  localparam int unsigned SLOT_OFFSET = 2;
  localparam int unsigned SLOTS       = BOARDS * CHANNELS;

  localparam int CLK_PERIOD    = 12;
  localparam int SETTLE_CYCLES = 40;
  localparam int HOLD_CYCLES   = 300;
  localparam int PHASE_ITEMS   = 80;
  localparam int MAX_REPORTS   = 10;
  localparam longint TIMEOUT_NS = 64'd12_000_000;

  // Tracks open event, per-slot maxima and the queue of event readouts owed.
  class event_scoreboard;
    logic [WINDOW_W-1:0] window;
    bit                  evt_open;
    logic [63:0]         start_ns;
    logic [EVT_W-1:0]    evt_count;
    entry_t              entries[SLOTS];
    result_t             expected[$];
    int                  errors;

    function new();
      window    = WINDOW_RESET;
      evt_open  = 1'b0;
      start_ns  = '0;
      evt_count = '0;
      errors    = 0;
      clear_entries();
    endfunction

    function void clear_entries();
      foreach (entries[k]) entries[k] = '0;
    endfunction

    function void keep_hit(hit_t h);
      int unsigned b;
      int unsigned idx;
      if (h.slot < SLOT_OFFSET) return;
      b = h.slot - SLOT_OFFSET;
      if (b >= BOARDS || h.channel >= CHANNELS) return;
      idx = b * CHANNELS + h.channel;
      // strictly larger only, so zero energy never lands
      if (h.energy > entries[idx].energy) begin
        entries[idx].energy    = h.energy;
        entries[idx].timestamp = h.timestamp;
        entries[idx].cfd       = h.cfd_fraction;
        entries[idx].forced    = h.cfd_forced;
      end
    endfunction

    function void close_event();
      result_t r;
      for (int i = 0; i < SLOTS; i++) begin
        r.event_number   = evt_count;
        r.board          = BOARD_W'(i / CHANNELS);
        r.out_channel    = CHAN_W'(i % CHANNELS);
        r.max_energy     = entries[i].energy;
        r.hit_time       = entries[i].timestamp;
        r.hit_cfd        = entries[i].cfd;
        r.hit_cfd_forced = entries[i].forced;
        r.last           = (i == SLOTS - 1);
        expected.push_back(r);
      end
      evt_count++;
      clear_entries();
    endfunction

    function void start_event(hit_t h);
      clear_entries();
      start_ns = 64'(h.timestamp) * 64'd10;
      keep_hit(h);
      evt_open = 1'b1;
    endfunction

    function void note_input(hit_t h);
      logic [63:0] t_ns;
      if (h.op == OP_FLUSH) begin
        if (evt_open) begin
          close_event();
          evt_open = 1'b0;
        end
        return;
      end
      if (!evt_open) begin
        start_event(h);
        return;
      end
      // unsigned wrap: an earlier hit lands far outside the window
      t_ns = 64'(h.timestamp) * 64'd10;
      if (t_ns - start_ns <= 64'(window)) begin
        keep_hit(h);
        return;
      end
      close_event();
      start_event(h);
    endfunction

    function string describe(result_t r);
      return $sformatf("evt=%0d brd=%0d ch=%0d e=%h t=%h cfd=%h frc=%b last=%b",
                       r.event_number, r.board, r.out_channel, r.max_energy,
                       r.hit_time, r.hit_cfd, r.hit_cfd_forced, r.last);
    endfunction

    function void flag(string msg);
      errors++;
      if (errors <= MAX_REPORTS) $display("[%0t] mismatch: %s", $time, msg);
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (expected.size() == 0) begin
        flag({"result with nothing pending: ", describe(got)});
        return;
      end
      want = expected.pop_front();
      if (got.event_number !== want.event_number || got.board !== want.board ||
          got.out_channel !== want.out_channel || got.max_energy !== want.max_energy ||
          got.hit_time !== want.hit_time || got.hit_cfd !== want.hit_cfd ||
          got.hit_cfd_forced !== want.hit_cfd_forced || got.last !== want.last)
        flag({"expected ", describe(want), " got ", describe(got)});
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_stall_o;
  hit_t                in_data_i;
  logic                out_valid_o;
  logic                out_stall_i;
  result_t             out_data_o;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [WINDOW_W-1:0] cfg_data_i;

  event_scoreboard     sb;
  int                  sender_idle_pct;
  int                  receiver_stall_pct;
  logic                hold_off;
  bit                  pressure_go;
  logic [WINDOW_W-1:0] cur_window;
  logic [TS_W-1:0]     evt_base;
  int                  items_sent;

  time_window_event_builder #(
    .BOARDS     (BOARDS),
    .CHANNELS   (CHANNELS),
    .SLOT_OFFSET(SLOT_OFFSET)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #(CLK_PERIOD / 2) clk_i = ~clk_i;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("FAIL");
    $finish;
  end

  // long receiver hold-off, counted here while the sender keeps offering
  initial begin
    hold_off <= 1'b0;
    wait (pressure_go);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    hold_off <= 1'b0;
  end

  initial begin
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      out_stall_i <= hold_off || ($urandom_range(99) < receiver_stall_pct);
    end
  end

  initial begin
    forever begin
      @(posedge clk_i);
      if (rst_ni === 1'b1 && out_valid_o === 1'b1 && out_stall_i === 1'b0)
        sb.check_result(out_data_o);
    end
  end

  task automatic send_item(input hit_t h);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= h;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    sb.note_input(h);
    items_sent++;
  endtask

  function automatic hit_t mk_hit(logic [TS_W-1:0] ts, logic [SLOT_W-1:0] slot,
                                  logic [CHAN_W-1:0] ch, logic [ENERGY_W-1:0] e,
                                  logic [CFD_W-1:0] cfd, logic forced);
    hit_t h;
    h.op           = OP_HIT;
    h.energy       = e;
    h.timestamp    = ts;
    h.channel      = ch;
    h.slot         = slot;
    h.cfd_fraction = cfd;
    h.cfd_forced   = forced;
    return h;
  endfunction

  function automatic hit_t rand_hit(logic [TS_W-1:0] ts);
    logic [SLOT_W-1:0]   slot;
    logic [CHAN_W-1:0]   ch;
    logic [ENERGY_W-1:0] e;
    slot = ($urandom_range(4) != 0) ? SLOT_W'($urandom_range(2, 5)) : SLOT_W'($urandom);
    // narrow channel range half the time so entries collide
    ch = ($urandom_range(1) == 0) ? CHAN_W'($urandom_range(0, 3)) : CHAN_W'($urandom);
    case ($urandom_range(9))
      0: e = '0;
      1: e = '1;
      default: e = ENERGY_W'($urandom);
    endcase
    return mk_hit(ts, slot, ch, e, CFD_W'($urandom), 1'($urandom));
  endfunction

  task automatic send_flush();
    hit_t h;
    h    = rand_hit(TS_W'({$urandom, $urandom}));
    h.op = OP_FLUSH;
    send_item(h);
  endtask

  // one event's worth of hits, mostly inside the window, with some noise
  task automatic send_burst();
    logic [TS_W-1:0] base;
    logic [TS_W-1:0] span;
    logic [TS_W-1:0] ts;
    int unsigned     lim;
    int              n;
    span = TS_W'(cur_window / 10);
    lim  = (span > 2000) ? 2000 : span[31:0];
    if ($urandom_range(9) == 0) base = TS_W'({$urandom, $urandom});
    else base = evt_base + span + TS_W'($urandom_range(1, 40));
    evt_base = base;
    n = $urandom_range(1, 8);
    for (int k = 0; k < n; k++) begin
      if (k == 0) ts = base;
      else if ($urandom_range(19) == 0) ts = base - TS_W'($urandom_range(1, 50));
      else if ($urandom_range(15) == 0) ts = base + span + 1;
      else if ($urandom_range(3) == 0) ts = base + span;
      else ts = base + TS_W'($urandom_range(0, lim));
      send_item(rand_hit(ts));
    end
    if ($urandom_range(7) == 0) begin
      send_flush();
      if ($urandom_range(3) == 0) send_flush();
    end
  endtask

  // drain outstanding readouts, then let queued stores finish
  task automatic settle();
    in_valid_i <= 1'b0;
    while (sb.expected.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_window(input logic [WINDOW_W-1:0] w);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= w;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    cfg_valid_i <= 1'b0;
    sb.window  = w;
    cur_window = w;
  endtask

  task automatic run_phase(input logic [WINDOW_W-1:0] w, input int idle_pct,
                           input int stall_pct, input bit squeeze);
    int goal;
    settle();
    write_window(w);
    sender_idle_pct    = idle_pct;
    receiver_stall_pct = stall_pct;
    if (squeeze) pressure_go = 1'b1;
    goal = items_sent + PHASE_ITEMS;
    while (items_sent < goal) send_burst();
  endtask

  initial begin
    sb = new();
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    in_data_i   <= '0;
    cfg_valid_i <= 1'b0;
    cfg_data_i  <= '0;
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    pressure_go = 1'b0;
    items_sent  = 0;
    cur_window  = WINDOW_RESET;
    evt_base    = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: window at its reset value, event starts at 1000 ns
    send_flush();
    send_item(mk_hit(48'd100, 4'd2, 4'd0, 16'd500, 16'h0000, 1'b0));
    send_item(mk_hit(48'd100, 4'd2, 4'd0, 16'd500, 16'h1234, 1'b1));
    send_item(mk_hit(48'd150, 4'd2, 4'd0, 16'd600, 16'hFFFF, 1'b1));
    send_item(mk_hit(48'd120, 4'd3, 4'd5, 16'd0, 16'hAAAA, 1'b1));
    send_item(mk_hit(48'd130, 4'd0, 4'd1, 16'hFFFF, 16'h5555, 1'b0));
    send_item(mk_hit(48'd130, 4'd1, 4'd2, 16'hFFFF, 16'h5555, 1'b1));
    send_item(mk_hit(48'd140, 4'd6, 4'd3, 16'h1234, 16'h0F0F, 1'b0));
    send_item(mk_hit(48'd140, 4'd15, 4'd15, 16'd1, 16'hF0F0, 1'b1));
    send_item(mk_hit(48'd200, 4'd5, 4'd15, 16'hFFFF, 16'hFFFF, 1'b1));
    send_item(mk_hit(48'd160, 4'd4, 4'd8, 16'd7, 16'h0001, 1'b0));
    send_item(mk_hit(48'd201, 4'd4, 4'd7, 16'd42, 16'h8000, 1'b1));
    send_item(mk_hit(48'd50, 4'd2, 4'd1, 16'd9, 16'h7FFF, 1'b0));
    send_flush();
    send_flush();
    send_item(mk_hit('1, 4'd2, 4'd3, 16'hFFFF, 16'hFFFF, 1'b1));
    send_item(mk_hit(48'd0, 4'd5, 4'd0, 16'd1, 16'h0000, 1'b0));
    send_item(mk_hit(48'd0, 4'd3, 4'd8, 16'd1, 16'h00FF, 1'b1));
    send_item(mk_hit(48'd100, 4'd2, 4'd15, 16'h8000, 16'hFF00, 1'b0));
    send_flush();

    run_phase(WINDOW_RESET, 0, 0, 1'b0);
    run_phase('0, 48, 0, 1'b0);
    run_phase('1, 0, 48, 1'b0);
    run_phase(WINDOW_W'($urandom_range(20, 100000)), 13, 13, 1'b0);
    run_phase(WINDOW_W'(200), 0, 0, 1'b1);

    send_flush();
    settle();
    if (sb.errors == 0 && sb.expected.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

### filelist.f
hw/rtl/twb_pkg.sv
hw/rtl/twb_ram.sv
hw/rtl/twb_front.sv
hw/rtl/twb_cmd_fifo.sv
hw/rtl/twb_back.sv
hw/rtl/time_window_event_builder.sv
dv/tb.sv
